>>> rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants for the track slot table
// Op codes, payload structs, controller/datapath command and status.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam logic [11:0] TTL_DEFAULT     = 12'd60;
  localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_PRUNE  = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_EXISTING = 2'd0;
  localparam logic [1:0] KIND_FREE     = 2'd1;
  localparam logic [1:0] KIND_EVICT    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        tracker_id;
    logic [15:0]        identity_code;
    logic signed [15:0] similarity;
    logic [47:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic [1:0]         slot_kind;
    logic               kept_valid;
    logic               dropped_valid;
    logic [3:0]         dropped_slot;
    logic [15:0]        found_identity;
    logic signed [15:0] found_similarity;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, clear scan index
    logic scan_step; // evaluate current entry, advance index
    logic write;     // write chosen slot
    logic clear_cnt; // zero in-use count
    logic [1:0] mode;  // which scan: one of the SCAN_ kinds below
    logic dedup;     // scan in dedup mode
  } dp_cmd_t;

  localparam logic [1:0] SCAN_MATCH = 2'd0;
  localparam logic [1:0] SCAN_FREE  = 2'd1;
  localparam logic [1:0] SCAN_OLD   = 2'd2;
  localparam logic [1:0] SCAN_PRUNE = 2'd3;

  // datapath -> controller
  typedef struct packed {
    logic last;   // scan index at last slot
    logic hit;    // current scan has found its entry
  } dp_sts_t;

endpackage

>>> rtl/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl: sequencer for the slot table
// Steps each update, prune or find op through its table scans, one slot per cycle.
// ----------------------------------------------------------------------------
module tst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  tst_pkg::dp_sts_t  sts,
  output tst_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import tst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_OLD   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DEDUP = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] op_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_r  <= OP_UPDATE;
    end else begin
      state <= state_next;
      if (start && !busy) op_r <= op;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op)
            OP_UPDATE: state_next = S_MATCH;
            OP_CLEAR: begin
              cmd.clear_cnt = 1'b1;
              state_next = S_DONE;
            end
            default: state_next = S_SCAN;
          endcase
        end
      end
      S_MATCH: begin
        cmd.scan_step = 1'b1;
        cmd.mode = SCAN_MATCH;
        if (sts.hit) state_next = S_WRITE;
        else if (sts.last) state_next = S_FREE;
      end
      S_FREE: begin
        cmd.scan_step = 1'b1;
        cmd.mode = SCAN_FREE;
        if (sts.hit) state_next = S_WRITE;
        else if (sts.last) state_next = S_OLD;
      end
      S_OLD: begin
        cmd.scan_step = 1'b1;
        cmd.mode = SCAN_OLD;
        if (sts.last) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_next = S_DEDUP;
      end
      S_DEDUP: begin
        cmd.scan_step = 1'b1;
        cmd.dedup = 1'b1;
        if (sts.hit || sts.last) state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.mode = (op_r == OP_PRUNE) ? SCAN_PRUNE : SCAN_MATCH;
        if (sts.last || (op_r == OP_FIND && sts.hit)) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_write_dedup: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> cmd.dedup) else $error("write not followed by dedup");
  a_idle_nobusy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
endmodule

>>> rtl/tst_dp.sv
// ----------------------------------------------------------------------------
// tst_dp: slot table storage and scan datapath
// Entry fields in a memory, valid bits in flops, one slot compared per cycle.
// ----------------------------------------------------------------------------
module tst_dp #(
  parameter int unsigned ENTRIES = tst_pkg::ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  tst_pkg::in_item_t in_word,
  input  logic [11:0]       ttl_seconds,
  input  tst_pkg::dp_cmd_t  cmd,
  input  logic              done,
  output tst_pkg::dp_sts_t  sts,
  output tst_pkg::out_item_t result
);
  import tst_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [15:0]        track;
    logic [15:0]        identity;
    logic signed [15:0] score;
    logic [47:0]        seen;
  } entry_t;

  entry_t      mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0] count;
  in_item_t    item;
  logic [IW-1:0] idx;
  logic [IW-1:0] sel;       // chosen slot
  logic [1:0]  kind;
  logic [47:0] best_seen;
  logic        dropped;
  logic [IW-1:0] dslot;
  logic [15:0] fid;
  logic signed [15:0] fsim;
  logic [21:0] ttl_ms;

  entry_t      e;
  logic        in_lim, expired, is_last, cur_hit;
  logic [11:0] ttl_eff;
  logic [47:0] age;

  always_comb begin
    e        = mem[idx];
    in_lim   = ({{(32-IW){1'b0}}, idx} < {{(32-CW){1'b0}}, count});
    age      = item.now_ms - e.seen;
    expired  = (item.now_ms > e.seen) && (age > {26'd0, ttl_ms});
    is_last  = ({{(32-IW){1'b0}}, idx} == ENTRIES - 1);
    ttl_eff  = (ttl_seconds == 12'd0) ? TTL_DEFAULT : ttl_seconds;
    cur_hit  = 1'b0;
    if (cmd.dedup) begin
      cur_hit = in_lim && (idx != sel) && valid[idx]
                && (e.identity == item.identity_code)
                && (item.identity_code >= 16'd2);
    end else begin
      unique case (cmd.mode)
        SCAN_MATCH: cur_hit = in_lim && valid[idx] && (e.track == item.tracker_id);
        SCAN_FREE:  cur_hit = !valid[idx] || expired;
        default:    cur_hit = 1'b0;
      endcase
    end
  end

  assign sts.hit  = cur_hit;
  assign sts.last = is_last;

  // ttl in ms, registered off the config value (config changes only while idle)
  always_ff @(posedge clk) begin
    ttl_ms <= ttl_eff * MS_PER_SEC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (cmd.clear_cnt) count <= '0;
      if (cmd.write) begin
        valid[sel] <= 1'b1;
        if (kind != KIND_EXISTING && {{(CW-IW){1'b0}}, sel} >= count)
          count <= CW'({{(32-IW){1'b0}}, sel} + 1);
      end
      if (cmd.scan_step && !cmd.dedup && cmd.mode == SCAN_PRUNE
          && in_lim && valid[idx] && expired)
        valid[idx] <= 1'b0;
      if (cmd.scan_step && cmd.dedup && cur_hit) begin
        if (e.score >= item.similarity) valid[sel] <= 1'b0;
        else valid[idx] <= 1'b0;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) mem[i] <= '0;
    end else if (cmd.write) begin
      mem[sel] <= '{item.tracker_id, item.identity_code, item.similarity, item.now_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item      <= in_word;
      idx       <= '0;
      sel       <= '0;
      kind      <= KIND_NONE;
      dropped   <= 1'b0;
      dslot     <= '0;
      fid       <= '0;
      fsim      <= '0;
    end else if (cmd.write) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= is_last ? '0 : idx + IW'(1);
      if (cmd.dedup) begin
        if (cur_hit && e.score < item.similarity) begin
          dropped <= 1'b1;
          dslot   <= idx;
        end
      end else begin
        unique case (cmd.mode)
          SCAN_MATCH: if (cur_hit) begin
            sel  <= idx;
            kind <= KIND_EXISTING;
            fid  <= e.identity;
            fsim <= e.score;
          end
          SCAN_FREE: if (cur_hit) begin
            sel  <= idx;
            kind <= KIND_FREE;
          end
          SCAN_OLD: begin
            if (idx == '0 || e.seen < best_seen) begin
              sel       <= idx;
              best_seen <= e.seen;
            end
            kind <= KIND_EVICT;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    result = '0;
    if (item.op == OP_UPDATE) begin
      result.slot          = 4'(sel);
      result.slot_kind     = kind;
      result.kept_valid    = valid[sel];
      result.dropped_valid = dropped;
      result.dropped_slot  = 4'(dslot);
    end else if (item.op == OP_FIND) begin
      result.slot_kind = kind;
      if (kind == KIND_EXISTING) begin
        result.slot             = 4'(sel);
        result.found_identity   = fid;
        result.found_similarity = fsim;
      end
    end else begin
      result.slot_kind = KIND_NONE;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES)) else $error("count above table depth");
  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> valid[$past(sel)]) else $error("written slot not valid");
  a_done_upd: assert property (@(posedge clk) disable iff (rst)
    (done && item.op == OP_UPDATE) |-> kind != KIND_NONE)
    else $error("update without slot");
endmodule

>>> rtl/track_slot_table_with_ttl.sv
// ----------------------------------------------------------------------------
// track_slot_table_with_ttl: tracked-object slot table with lifetime
// Update, prune, find and clear on a table of tracked entries.
// ----------------------------------------------------------------------------
// Usage: drive in_word and pulse start while busy is low; the word is taken
// at that edge and busy rises. Each word gives exactly one result word on
// result, marked by done for one cycle; the receiver cannot stall it.
// An op walks these states, one slot examined per cycle: clear goes straight
// to the result; find and prune run one scan; update runs the match scan, the
// free/expired scan, the oldest scan, a write, the dedup scan and the result,
// and skips the later scans once a slot is found.
// Next word can start the cycle after done, so the block takes no new word
// before the last one is through. Throughput is set by the single table read
// port walking the slots.
// The cfg channel (cfg_valid/cfg_ready) writes ttl_seconds; ready only while
// idle. Reset clears all entries, the in-use count, and sets ttl to 60 s.
// ----------------------------------------------------------------------------
module track_slot_table_with_ttl #(
  parameter int unsigned ENTRIES = tst_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tst_pkg::in_item_t   in_word,
  output logic                busy,
  output logic                done,
  output tst_pkg::out_item_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [11:0]         cfg_data
);
  import tst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [11:0] ttl_seconds;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) ttl_seconds <= TTL_DEFAULT;
    else if (cfg_valid && cfg_ready) ttl_seconds <= cfg_data;
  end

  tst_ctrl u_ctrl (
    .clk, .rst, .start, .op(in_word.op), .sts, .cmd, .busy, .done
  );

  tst_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .in_word, .ttl_seconds, .cmd, .done, .sts, .result
  );
endmodule

>>> test/track_slot_table_with_ttl_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_slot_table_with_ttl_test: self-checking bench for the track slot table
// Drives update/prune/find/clear words with random gaps, predicts each result
// from a local copy of the table and the ttl, and checks every result word.
// ----------------------------------------------------------------------------
module track_slot_table_with_ttl_test;
  import tst_pkg::*;

  localparam int N = 16;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  in_item_t   in_word = '0;
  logic       busy;
  logic       done;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [11:0] cfg_data = '0;

  track_slot_table_with_ttl dut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word), .busy(busy),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table shadow
  logic               tbl_valid [N];
  logic [15:0]        tbl_track [N];
  logic [15:0]        tbl_ident [N];
  logic signed [15:0] tbl_score [N];
  logic [47:0]        tbl_seen [N];
  int                 in_use;
  logic [11:0]        ttl_sec;

  out_item_t pending_results[$];
  int        errors = 0;
  bit        gaps_on = 1'b1;
  logic [47:0] clock_ms = 48'd0;

  function automatic bit aged_out(int i, logic [47:0] now);
    logic [47:0] life;
    life = 48'(ttl_sec == 0 ? 12'd60 : ttl_sec) * 48'd1000;
    return now > tbl_seen[i] && (now - tbl_seen[i]) > life;
  endfunction

  function automatic out_item_t table_step(in_item_t w);
    out_item_t r;
    bit hit;
    r = '0;
    r.slot_kind = KIND_NONE;
    hit = 1'b0;
    case (w.op)
      OP_UPDATE: begin
        for (int i = 0; i < in_use && !hit; i++)
          if (tbl_valid[i] && tbl_track[i] == w.tracker_id) begin
            r.slot = 4'(i); r.slot_kind = KIND_EXISTING; hit = 1'b1;
          end
        for (int i = 0; i < N && !hit; i++)
          if (!tbl_valid[i] || aged_out(i, w.now_ms)) begin
            r.slot = 4'(i); r.slot_kind = KIND_FREE; hit = 1'b1;
          end
        if (!hit) begin
          r.slot = 0; r.slot_kind = KIND_EVICT;
          for (int i = 1; i < N; i++)
            if (tbl_seen[i] < tbl_seen[r.slot]) r.slot = 4'(i);
        end
        if (r.slot_kind != KIND_EXISTING && r.slot + 1 > in_use) in_use = r.slot + 1;
        tbl_track[r.slot] = w.tracker_id;
        tbl_ident[r.slot] = w.identity_code;
        tbl_score[r.slot] = w.similarity;
        tbl_seen[r.slot]  = w.now_ms;
        tbl_valid[r.slot] = 1'b1;
        if (w.identity_code >= 2) begin
          hit = 1'b0;
          for (int i = 0; i < in_use && !hit; i++)
            if (i != r.slot && tbl_valid[i] && tbl_ident[i] == w.identity_code) begin
              hit = 1'b1;
              if (tbl_score[i] >= w.similarity) tbl_valid[r.slot] = 1'b0;
              else begin
                tbl_valid[i] = 1'b0; r.dropped_valid = 1'b1; r.dropped_slot = 4'(i);
              end
            end
        end
        r.kept_valid = tbl_valid[r.slot];
      end
      OP_PRUNE:
        for (int i = 0; i < in_use; i++)
          if (tbl_valid[i] && aged_out(i, w.now_ms)) tbl_valid[i] = 1'b0;
      OP_FIND:
        for (int i = 0; i < in_use && !hit; i++)
          if (tbl_valid[i] && tbl_track[i] == w.tracker_id) begin
            hit = 1'b1; r.slot = 4'(i); r.slot_kind = KIND_EXISTING;
            r.found_identity = tbl_ident[i]; r.found_similarity = tbl_score[i];
          end
      default: in_use = 0;
    endcase
    return r;
  endfunction

  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
  endtask

  task automatic send_word(logic [1:0] op, logic [15:0] tid, logic [15:0] code,
                           logic signed [15:0] sim, logic [47:0] now);
    in_item_t w;
    w = '{op: op, tracker_id: tid, identity_code: code, similarity: sim, now_ms: now};
    // start was dropped at the last falling edge; raise it on a later one
    @(negedge clk);
    idle_gap();
    in_word <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(table_step(w));
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk); guard++;
    end
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_ttl(logic [11:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ttl_sec = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // time steps: mostly small, sometimes past the ttl
  function automatic logic [47:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) clock_ms += 48'($urandom_range(0, 500));
    else if (r < 9) clock_ms += 48'($urandom_range(0, 2 * 1000 * (ttl_sec == 0 ? 60 : ttl_sec)));
    else if (clock_ms > 2000 && $urandom_range(0, 1)) return clock_ms - 48'($urandom_range(1, 2000));
    return clock_ms;
  endfunction

  task automatic test_directed();
    send_word(OP_FIND, 16'h0, 16'h0, 16'sh0, 48'd0);
    send_word(OP_UPDATE, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 48'd10);
    send_word(OP_UPDATE, 16'h0000, 16'hFFFF, -16'sd32768, 48'd20);
    send_word(OP_UPDATE, 16'h0001, 16'h0002, 16'sh4000, 48'd30);
    send_word(OP_UPDATE, 16'h0002, 16'h0002, 16'sh5000, 48'd40);
    send_word(OP_UPDATE, 16'h0003, 16'h0002, 16'sh5000, 48'd50);
    send_word(OP_UPDATE, 16'h0004, 16'h0001, 16'sh0, 48'd60);
    send_word(OP_FIND, 16'hFFFF, 16'h0, 16'sh0, 48'd70);
    send_word(OP_FIND, 16'h0002, 16'h0, 16'sh0, 48'd70);
    send_word(OP_UPDATE, 16'hFFFF, 16'h0, 16'sh1, 48'd80);
    for (int i = 0; i < 14; i++)
      send_word(OP_UPDATE, 16'(100 + i), 16'h0, 16'sh0, 48'd100);
    send_word(OP_UPDATE, 16'd500, 16'h0, 16'sh0, 48'd90);
    send_word(OP_CLEAR, 16'h0, 16'h0, 16'sh0, 48'd90);
    send_word(OP_FIND, 16'd101, 16'h0, 16'sh0, 48'd90);
    send_word(OP_UPDATE, 16'd700, 16'h0, 16'sh0, 48'd200000);
    send_word(OP_PRUNE, 16'h0, 16'h0, 16'sh0, 48'hFFFF_FFFF_FFFF);
    send_word(OP_UPDATE, 16'd701, 16'h0, 16'sh0, 48'd5);
    clock_ms = 48'd300000;
  endtask

  task automatic test_ttl_extremes();
    write_ttl(12'd1);
    for (int i = 0; i < 60; i++)
      send_word(2'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0),
                16'($urandom_range(0, 20)), 16'($urandom_range(0, 5)),
                16'($urandom), next_time());
    write_ttl(12'd0);
    write_ttl(12'd4095);
    write_ttl(12'd3600);
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    int unsigned r;
    logic [15:0] tid, code;
    for (int i = 0; i < count; i++) begin
      if (i == count - 150) gaps_on = 1'b0;
      if (i % 300 == 150) write_ttl(12'($urandom_range(1, 5)));
      r = $urandom_range(0, 99);
      op = r < 60 ? OP_UPDATE : r < 75 ? OP_FIND : r < 95 ? OP_PRUNE : OP_CLEAR;
      tid = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 24));
      r = $urandom_range(0, 9);
      code = r < 2 ? 16'(r) : r < 8 ? 16'($urandom_range(2, 6)) : 16'($urandom);
      send_word(op, tid, code, 16'($urandom), next_time());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.slot !== exp_r.slot) begin
          $error("slot exp %0d got %0d", exp_r.slot, result.slot); errors++;
        end
        if (result.slot_kind !== exp_r.slot_kind) begin
          $error("slot_kind exp %0d got %0d", exp_r.slot_kind, result.slot_kind); errors++;
        end
        if (result.kept_valid !== exp_r.kept_valid) begin
          $error("kept_valid exp %0d got %0d", exp_r.kept_valid, result.kept_valid); errors++;
        end
        if (result.dropped_valid !== exp_r.dropped_valid) begin
          $error("dropped_valid exp %0d got %0d", exp_r.dropped_valid, result.dropped_valid);
          errors++;
        end
        if (result.dropped_slot !== exp_r.dropped_slot) begin
          $error("dropped_slot exp %0d got %0d", exp_r.dropped_slot, result.dropped_slot);
          errors++;
        end
        if (result.found_identity !== exp_r.found_identity) begin
          $error("found_identity exp %0d got %0d", exp_r.found_identity, result.found_identity);
          errors++;
        end
        if (result.found_similarity !== exp_r.found_similarity) begin
          $error("found_similarity exp %0d got %0d", exp_r.found_similarity,
                 result.found_similarity);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < N; i++) begin
      tbl_valid[i] = 0; tbl_track[i] = 0; tbl_ident[i] = 0; tbl_score[i] = 0; tbl_seen[i] = 0;
    end
    in_use = 0;
    ttl_sec = 12'd60;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_ttl_extremes();
    test_random(1450);
    drain();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> filelist.f
rtl/tst_pkg.sv
rtl/tst_ctrl.sv
rtl/tst_dp.sv
rtl/track_slot_table_with_ttl.sv
test/track_slot_table_with_ttl_test.sv
